// ===== src/pht_pkg.sv =====
package pht_pkg;

   localparam int HAND_SIZE = 5;
   localparam int NUM_CAT   = 7;
   localparam int DIGIT_W   = 4;
   localparam int COUNT_W   = 3;
   localparam int POS_W     = 3;
   localparam int CAT_W     = 3;
   localparam int TALLY_W   = 16;
   localparam int HPB_W     = 16;
   localparam logic [HPB_W-1:0] HPB_RESET = 16'd40000;
   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   typedef enum logic [CAT_W-1:0] {
      CAT_BUST  = 3'd0,
      CAT_PAIR  = 3'd1,
      CAT_TWO   = 3'd2,
      CAT_THREE = 3'd3,
      CAT_FULL  = 3'd4,
      CAT_FOUR  = 3'd5,
      CAT_FIVE  = 3'd6
   } cat_type;

   typedef enum logic {
      KIND_DIGIT = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   typedef logic [NUM_CAT-1:0][TALLY_W-1:0] tally_vec_type;

endpackage

// ===== src/pht_req_if.sv =====
interface pht_req_if import pht_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [DIGIT_W-1:0] digit;

   modport source (output valid, output kind, output digit, input ready);
   modport sink (input valid, input kind, input digit, output ready);
endinterface

// ===== src/pht_rsp_if.sv =====
interface pht_rsp_if import pht_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CAT_W-1:0]   category;
   logic [TALLY_W-1:0] tally;
   logic               last;

   modport source (output valid, output category, output tally, output last, input ready);
   modport sink (input valid, input category, input tally, input last, output ready);
endinterface

// ===== src/pht_classify.sv =====
module pht_classify import pht_pkg::*; #(
   parameter int ALPHABET_SIZE = 10
) (
   input  logic [ALPHABET_SIZE-1:0][COUNT_W-1:0] counts,
   output cat_type                               category
);

   logic [ALPHABET_SIZE-1:0] is_pair;
   logic [ALPHABET_SIZE-1:0] is_three;
   logic [ALPHABET_SIZE-1:0] is_four;
   logic [ALPHABET_SIZE-1:0] is_five;

   always_comb begin
      for (int d = 0; d < ALPHABET_SIZE; d++) begin
         is_pair[d]  = (counts[d] == COUNT_W'(2));
         is_three[d] = (counts[d] == COUNT_W'(3));
         is_four[d]  = (counts[d] == COUNT_W'(4));
         is_five[d]  = (counts[d] == COUNT_W'(5));
      end
   end

   always_comb begin
      if (|is_five) begin
         category = CAT_FIVE;
      end else if (|is_four) begin
         category = CAT_FOUR;
      end else if ((|is_three) && (|is_pair)) begin
         category = CAT_FULL;
      end else if (|is_three) begin
         category = CAT_THREE;
      end else if ($countones(is_pair) >= 2) begin
         category = CAT_TWO;
      end else if (|is_pair) begin
         category = CAT_PAIR;
      end else begin
         category = CAT_BUST;
      end
   end

endmodule

// ===== src/poker_hand_tally.sv =====
// dump path: a request that closes a block, or a flush, is held in the s1 register, then
//   loads the dump buffer; the seven tallies follow on consecutive cycles when rsp is ready
// throughput: one request per cycle; input stalls only when a new dump is due while the
//   seven-entry dump buffer still holds the previous one
// reset: synchronous, active high; clears hand, tallies, block count, dump buffer state
//   and sets hands_per_block to 40000
module poker_hand_tally import pht_pkg::*; #(
   parameter int ALPHABET_SIZE = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [HPB_W-1:0] csr_wr_data,
   pht_req_if.sink          req_chan,
   pht_rsp_if.source        rsp_chan
);

   localparam logic [DIGIT_W:0] ALPHA_LIM = (DIGIT_W+1)'(ALPHABET_SIZE);

   logic                                 s1_valid_ff;
   logic                                 s1_kind_ff;
   logic [DIGIT_W-1:0]                   s1_digit_ff;
   logic [HPB_W-1:0]                     hpb_ff;
   logic [ALPHABET_SIZE-1:0][COUNT_W-1:0] counts_ff;
   logic [ALPHABET_SIZE-1:0][COUNT_W-1:0] counts_in;
   logic [ALPHABET_SIZE-1:0][COUNT_W-1:0] counts_inc;
   logic [POS_W-1:0]                     hand_pos_ff;
   logic [POS_W-1:0]                     hand_pos_in;
   tally_vec_type                        tally_ff;
   tally_vec_type                        tally_in;
   tally_vec_type                        tally_upd;
   logic [HPB_W-1:0]                     hands_ff;
   logic [HPB_W-1:0]                     hands_in;
   tally_vec_type                        dump_ff;
   tally_vec_type                        dump_src;
   logic [CAT_W-1:0]                     dump_idx_ff;
   logic                                 dump_busy_ff;

   cat_type        hand_cat;
   logic           in_range;
   logic           completes;
   logic           block_full;
   logic           want_dump;
   logic           dump_free;
   logic           s1_go;
   logic           load_dump;
   logic           rsp_take;
   logic           rsp_last;
   logic [HPB_W:0] hands_next;
   logic [HPB_W:0] limit;

   pht_classify #(
      .ALPHABET_SIZE(ALPHABET_SIZE)
   ) u_classify (
      .counts  (counts_inc),
      .category(hand_cat)
   );

   // request side
   assign in_range   = ({1'b0, s1_digit_ff} < ALPHA_LIM);
   assign completes  = (s1_kind_ff == KIND_DIGIT) && in_range &&
                       (hand_pos_ff == POS_W'(HAND_SIZE - 1));
   assign hands_next = {1'b0, hands_ff} + (HPB_W+1)'(1);
   assign limit      = (hpb_ff == '0) ? {1'b1, {HPB_W{1'b0}}} : {1'b0, hpb_ff};
   assign block_full = (hands_next >= limit);
   assign want_dump  = (s1_kind_ff == KIND_FLUSH) || (completes && block_full);

   assign rsp_take   = rsp_chan.valid && rsp_chan.ready;
   assign rsp_last   = (dump_idx_ff == CAT_FIVE);
   assign dump_free  = !dump_busy_ff || (rsp_chan.ready && rsp_last);
   assign s1_go      = s1_valid_ff && (!want_dump || dump_free);
   assign load_dump  = s1_go && want_dump;

   assign req_chan.ready = !s1_valid_ff || s1_go;

   always_comb begin
      for (int d = 0; d < ALPHABET_SIZE; d++) begin
         counts_inc[d] = counts_ff[d] + COUNT_W'(s1_digit_ff == DIGIT_W'(d));
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CAT; c++) begin
         tally_upd[c] = tally_ff[c];
         if ((hand_cat == CAT_W'(c)) && (tally_ff[c] != TALLY_MAX)) begin
            tally_upd[c] = tally_ff[c] + TALLY_W'(1);
         end
      end
   end

   always_comb begin
      counts_in   = counts_ff;
      hand_pos_in = hand_pos_ff;
      tally_in    = tally_ff;
      hands_in    = hands_ff;
      dump_src    = tally_ff;
      if (s1_go) begin
         if (s1_kind_ff == KIND_FLUSH) begin
            counts_in   = '0;
            hand_pos_in = '0;
            tally_in    = '0;
            hands_in    = '0;
         end else if (completes) begin
            counts_in   = '0;
            hand_pos_in = '0;
            dump_src    = tally_upd;
            if (block_full) begin
               tally_in = '0;
               hands_in = '0;
            end else begin
               tally_in = tally_upd;
               hands_in = hands_next[HPB_W-1:0];
            end
         end else if (in_range) begin
            counts_in   = counts_inc;
            hand_pos_in = hand_pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         hpb_ff      <= HPB_RESET;
         counts_ff   <= '0;
         hand_pos_ff <= '0;
         tally_ff    <= '0;
         hands_ff    <= '0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (csr_wr_en) begin
            hpb_ff <= csr_wr_data;
         end
         counts_ff   <= counts_in;
         hand_pos_ff <= hand_pos_in;
         tally_ff    <= tally_in;
         hands_ff    <= hands_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_kind_ff  <= req_chan.kind;
         s1_digit_ff <= req_chan.digit;
      end
   end

   // dump buffer, drained lowest category first
   always_ff @(posedge clock) begin
      if (reset) begin
         dump_busy_ff <= 1'b0;
         dump_idx_ff  <= '0;
      end else if (load_dump) begin
         dump_busy_ff <= 1'b1;
         dump_idx_ff  <= '0;
      end else if (rsp_take) begin
         dump_idx_ff <= dump_idx_ff + CAT_W'(1);
         if (rsp_last) begin
            dump_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_dump) begin
         dump_ff <= dump_src;
      end else if (rsp_take) begin
         for (int c = 0; c < NUM_CAT - 1; c++) begin
            dump_ff[c] <= dump_ff[c+1];
         end
      end
   end

   assign rsp_chan.valid    = dump_busy_ff;
   assign rsp_chan.category = dump_idx_ff;
   assign rsp_chan.tally    = dump_ff[0];
   assign rsp_chan.last     = rsp_last;

   // a dump streams without gaps once started
   a_dump_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last) |=> rsp_chan.valid)
      else $error("dump interrupted before last tally");

   // a new dump only overwrites the buffer as the old one finishes
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (load_dump && dump_busy_ff) |-> (rsp_take && rsp_last))
      else $error("dump buffer overwritten while busy");

   // open hand never reaches a full hand
   a_hand_pos: assert property (@(posedge clock) disable iff (reset)
      hand_pos_ff < POS_W'(HAND_SIZE))
      else $error("hand position out of range");

   // a dump always starts at the first category
   a_dump_start: assert property (@(posedge clock) disable iff (reset)
      load_dump |=> (dump_idx_ff == CAT_BUST) && rsp_chan.valid)
      else $error("dump did not start at first category");

endmodule

// ===== test/pht_tally_checker.sv =====
module pht_tally_checker import pht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [HPB_W-1:0] csr_wr_data,
   pht_req_if               req_mon,
   pht_rsp_if               rsp_mon,
   output int               pending,
   output int               errors
);

   localparam int ALPHABET = 10;

   typedef struct packed {
      cat_type            category;
      logic [TALLY_W-1:0] tally;
      logic               last;
   } tally_rec_type;

   logic [HPB_W-1:0]   block_len;
   logic [COUNT_W-1:0] digit_cnt [ALPHABET];
   logic [POS_W-1:0]   hand_pos;
   logic [TALLY_W-1:0] cat_tally [NUM_CAT];
   int                 hands_done;
   int                 err_n;
   tally_rec_type      dump_q [$];

   function automatic void open_hand();
      foreach (digit_cnt[i]) digit_cnt[i] = '0;
      hand_pos = '0;
   endfunction

   function automatic void dump_tallies();
      tally_rec_type rec;
      for (int c = 0; c < NUM_CAT; c++) begin
         rec.category = cat_type'(c);
         rec.tally    = cat_tally[c];
         rec.last     = (c == NUM_CAT - 1);
         dump_q.insert(dump_q.size(), rec);
         cat_tally[c] = '0;
      end
      hands_done = 0;
   endfunction

   function automatic void tally_request(kind_type k, logic [DIGIT_W-1:0] d);
      int      prof [1:5];
      cat_type cat;
      int      lim;
      if (k == KIND_FLUSH) begin
         open_hand();
         dump_tallies();
         return;
      end
      // out-of-alphabet digits are dropped without advancing the hand
      if (d >= ALPHABET) return;
      digit_cnt[d]++;
      hand_pos++;
      if (hand_pos < HAND_SIZE) return;
      prof = '{default: 0};
      foreach (digit_cnt[i]) begin
         if (digit_cnt[i] >= 1 && digit_cnt[i] <= 5) prof[digit_cnt[i]]++;
      end
      if (prof[5] == 1) cat = CAT_FIVE;
      else if (prof[4] == 1) cat = CAT_FOUR;
      else if (prof[3] == 1 && prof[2] == 1) cat = CAT_FULL;
      else if (prof[3] == 1) cat = CAT_THREE;
      else if (prof[2] == 2) cat = CAT_TWO;
      else if (prof[2] == 1) cat = CAT_PAIR;
      else cat = CAT_BUST;
      if (cat_tally[cat] != TALLY_MAX) cat_tally[cat]++;
      open_hand();
      // zero length means a full 65536-hand block
      lim = (block_len == 0) ? 65536 : int'(block_len);
      if (hands_done + 1 >= lim) dump_tallies();
      else hands_done++;
   endfunction

   always @(posedge clock) begin
      tally_rec_type want;
      if (reset) begin
         block_len = HPB_RESET;
         open_hand();
         foreach (cat_tally[i]) cat_tally[i] = '0;
         hands_done = 0;
         err_n = 0;
         dump_q.delete();
      end else begin
         if (csr_wr_en) block_len = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            tally_request(kind_type'(req_mon.kind), req_mon.digit);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (dump_q.size() == 0) begin
               $display("%0t: expected none, got cat %0d tally %0d last %0d",
                        $time, rsp_mon.category, rsp_mon.tally, rsp_mon.last);
               err_n++;
            end else begin
               want = dump_q.pop_front();
               if (want.category != rsp_mon.category || want.tally != rsp_mon.tally ||
                   want.last != rsp_mon.last) begin
                  $display("%0t: expected cat %0d tally %0d last %0d, got %0d %0d %0d",
                           $time, want.category, want.tally, want.last,
                           rsp_mon.category, rsp_mon.tally, rsp_mon.last);
                  err_n++;
               end
            end
         end
      end
      pending <= dump_q.size();
      errors  <= err_n;
   end

endmodule

// ===== test/poker_hand_tally_tb.sv =====
module poker_hand_tally_tb;
   import pht_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE = 6;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [HPB_W-1:0] csr_wr_data;
   int               pending;
   int               errors;
   int               quiet_cycles;
   bit               pace_on = 1'b0;

   pht_req_if req_chan ();
   pht_rsp_if rsp_chan ();

   poker_hand_tally dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   pht_tally_checker hand_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .pending     (pending),
      .errors      (errors)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic send_req(input kind_type k, input logic [DIGIT_W-1:0] d);
      int gap;
      gap = pace_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind  <= k;
      req_chan.digit <= d;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_block_len(input logic [HPB_W-1:0] len);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // digits mostly from a narrow window so that the rarer hands show up
   task automatic play_random(input int n);
      int r;
      int span;
      int base;
      span = $urandom_range(1, 9);
      base = $urandom_range(0, 9 - span);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3) send_req(KIND_FLUSH, DIGIT_W'($urandom_range(0, 15)));
         else if (r < 10) send_req(KIND_DIGIT, DIGIT_W'($urandom_range(10, 15)));
         else send_req(KIND_DIGIT, DIGIT_W'(base + $urandom_range(0, span)));
      end
   endtask

   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pace_on ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [DIGIT_W-1:0] opening [$];
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_chan.valid <= 1'b0;
      req_chan.kind  <= KIND_DIGIT;
      req_chan.digit <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty flush, five, four, full house and three of a kind, stray digits mid-hand, partial hand dropped
      pace_on = 1'b1;
      send_req(KIND_FLUSH, 4'd15);
      opening = {4'd9, 4'd9, 4'd9, 4'd9, 4'd9,
                 4'd0, 4'd15, 4'd0, 4'd0, 4'd10, 4'd0, 4'd9,
                 4'd1, 4'd2, 4'd1, 4'd2, 4'd2,
                 4'd3, 4'd3, 4'd3, 4'd4, 4'd5,
                 4'd6, 4'd7};
      foreach (opening[i]) send_req(KIND_DIGIT, opening[i]);
      send_req(KIND_FLUSH, 4'd0);

      // block length lowered under the running count
      set_block_len(16'hFFFF);
      repeat (4 * HAND_SIZE) send_req(KIND_DIGIT, DIGIT_W'($urandom_range(0, 9)));
      set_block_len(16'd2);
      repeat (HAND_SIZE) send_req(KIND_DIGIT, DIGIT_W'($urandom_range(0, 9)));

      for (int ph = 0; ph < 4; ph++) begin
         set_block_len(HPB_W'((ph < 3) ? ph + 1 : $urandom_range(4, 6)));
         pace_on = (ph != 2);
         play_random(14);
      end
      send_req(KIND_FLUSH, 4'd5);

      // zero length acts as a 65536-hand block, so nothing comes out before the flush
      set_block_len(16'd0);
      repeat (2 * HAND_SIZE) send_req(KIND_DIGIT, DIGIT_W'($urandom_range(0, 9)));

      wait_idle();
      send_req(KIND_FLUSH, 4'd0);
      wait_idle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
